### design/c8cpu_pkg.sv
`timescale 1ns / 1ps
// c8cpu_pkg: shared types, constants and tables of the CHIP-8 style CPU.
// No dependencies; imported by bytecode_vm_cpu_with_sprite_display.
package c8cpu_pkg;

    localparam int MEM_BYTES_DEF   = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int ADDR_W          = 12;
    localparam int FONT_BYTES      = 80;
    localparam int ROWS            = 32;
    localparam int COLS            = 64;

    localparam logic [1:0] CMD_STEP = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_KEY  = 2'd2;
    localparam logic [1:0] CMD_ROW  = 2'd3;

    localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SEI  = 4'h3;
    localparam logic [3:0] OP_SNEI = 4'h4;
    localparam logic [3:0] OP_SER  = 4'h5;
    localparam logic [3:0] OP_LDI  = 4'h6;
    localparam logic [3:0] OP_ADDI = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNER = 4'h9;
    localparam logic [3:0] OP_LDIX = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_DOWN_SKIP = 8'h9E;
    localparam logic [7:0] KEY_UP_SKIP   = 8'hA1;
    localparam logic [7:0] F_GETDT = 8'h07;
    localparam logic [7:0] F_WAIT  = 8'h0A;
    localparam logic [7:0] F_SETDT = 8'h15;
    localparam logic [7:0] F_SETST = 8'h18;
    localparam logic [7:0] F_ADDI  = 8'h1E;
    localparam logic [7:0] F_FONT  = 8'h29;
    localparam logic [7:0] F_BCD   = 8'h33;
    localparam logic [7:0] F_SAVE  = 8'h55;
    localparam logic [7:0] F_LOAD  = 8'h65;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    localparam logic [3:0] PAD_MAP [16] = '{
        4'h1, 4'h2, 4'h3, 4'hC, 4'h4, 4'h5, 4'h6, 4'hD,
        4'h7, 4'h8, 4'h9, 4'hE, 4'hA, 4'h0, 4'hB, 4'hF
    };

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] address;
        logic [7:0]  data;
        logic [3:0]  key_code;
        logic        key_down;
        logic [7:0]  random_byte;
        logic [4:0]  row;
    } t_in;

    typedef struct packed {
        logic [11:0] pc_now;
        logic [15:0] opcode_done;
        logic        draw_pending;
        logic        beep;
        logic        waiting_key;
        logic [63:0] row_pixels;
    } t_out;

endpackage

### design/c8cpu_ram.sv
`timescale 1ns / 1ps
// c8cpu_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module c8cpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/bytecode_vm_cpu_with_sprite_display.sv
`timescale 1ns / 1ps
// CHIP-8 style CPU with a 64x32 one-bit XOR sprite display.
// Depends on c8cpu_pkg and c8cpu_ram.
//
// Usage: one input word per command (step, load byte, key event, read row)
// on i_in with i_in_valid / o_in_stall; one result word per command on
// o_out with o_out_valid / i_out_stall. Words are taken only while the
// sequencer is idle; a finished result sits in the output register, and
// the next command is accepted while it waits.
// Sequence: load byte and key event go from idle straight to the done
// state; read row reads the frame first. A step runs fetch, register
// reads, execute, timer tick and done, with a flag write, a return, a
// loop per sprite row or register, or the BCD writes between. Everything is
// bound by the single read port of main memory and the register file.
// Reset: main memory is swept once (font into 0..79, zero
// elsewhere) while no command is accepted. Frame rows, data registers and
// stack entries carry valid bits and read as zero until written.
// A stalled output holds its result; the sequencer waits in its final
// state until the output register frees up.
module bytecode_vm_cpu_with_sprite_display
    import c8cpu_pkg::*;
#(
    parameter int MEMORY_BYTES = MEM_BYTES_DEF,
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);
    localparam int MAW = $clog2(MEMORY_BYTES);
    localparam int SPW = $clog2(STACK_DEPTH);

    typedef enum logic [20:0] {
        S_CLR   = 21'h000001,
        S_IDLE  = 21'h000002,
        S_RDROW = 21'h000004,
        S_F0    = 21'h000008,
        S_F1    = 21'h000010,
        S_F2    = 21'h000020,
        S_RX    = 21'h000040,
        S_RY    = 21'h000080,
        S_EXEC  = 21'h000100,
        S_RET   = 21'h000200,
        S_WF    = 21'h000400,
        S_DM    = 21'h000800,
        S_DF    = 21'h001000,
        S_DW    = 21'h002000,
        S_BCD   = 21'h004000,
        S_SVR   = 21'h008000,
        S_SVW   = 21'h010000,
        S_LDR   = 21'h020000,
        S_LDW   = 21'h040000,
        S_TICK  = 21'h080000,
        S_DONE  = 21'h100000
    } t_state;

    function automatic logic [SPW-1:0] sp_inc(input logic [SPW-1:0] s);
        return (s == SPW'(STACK_DEPTH - 1)) ? '0 : s + SPW'(1);
    endfunction
    function automatic logic [SPW-1:0] sp_dec(input logic [SPW-1:0] s);
        return (s == '0) ? SPW'(STACK_DEPTH - 1) : s - SPW'(1);
    endfunction

    t_state r_state, n_state;
    logic [MAW:0]        r_clr, n_clr;
    logic [11:0]         r_pc, n_pc, r_i, n_i;
    logic [15:0]         r_op, n_op, r_keys, n_keys;
    logic [7:0]          r_vx, n_vx, r_vy, n_vy, r_dt, n_dt, r_st, n_st;
    logic [7:0]          r_bits, n_bits, r_rnd, n_rnd;
    logic [SPW-1:0]      r_sp, n_sp;
    logic [3:0]          r_cnt, n_cnt;
    logic                r_draw, n_draw, r_beep, n_beep, r_wait, n_wait;
    logic                r_hit, n_hit, r_flag, n_flag;
    logic [4:0]          r_row, n_row;
    logic [63:0]         r_pix, n_pix;
    logic [31:0]         r_fv, n_fv;
    logic [15:0]         r_rv, n_rv;
    logic [STACK_DEPTH-1:0] r_sv, n_sv;
    logic                r_ov, n_ov;
    t_out                r_out, n_out;

    // memory ports
    logic           w_mwe;
    logic [MAW-1:0] w_mwa, w_mra;
    logic [7:0]     w_mwd, w_mrd;
    logic           w_rwe;
    logic [3:0]     w_rwa, w_rra;
    logic [7:0]     w_rwd, w_rrd;
    logic           w_fwe;
    logic [4:0]     w_fwa, w_fra;
    logic [63:0]    w_fwd, w_frd;
    logic           w_swe;
    logic [11:0]    w_srd;

    c8cpu_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .i_clk(i_clk), .i_we(w_mwe), .i_waddr(w_mwa), .i_wdata(w_mwd),
        .i_raddr(w_mra), .o_rdata(w_mrd));
    c8cpu_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
        .i_clk(i_clk), .i_we(w_rwe), .i_waddr(w_rwa), .i_wdata(w_rwd),
        .i_raddr(w_rra), .o_rdata(w_rrd));
    c8cpu_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_frame (
        .i_clk(i_clk), .i_we(w_fwe), .i_waddr(w_fwa), .i_wdata(w_fwd),
        .i_raddr(w_fra), .o_rdata(w_frd));
    c8cpu_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(w_swe), .i_waddr(r_sp), .i_wdata(r_pc),
        .i_raddr(sp_dec(r_sp)), .o_rdata(w_srd));

    // opcode fields
    logic [3:0]  w_x, w_y, w_n, w_hi;
    logic [7:0]  w_nn, w_vy, w_rv, w_hund, w_rem, w_ten, w_one, w_key_hi;
    logic [11:0] w_nnn, w_pc2, w_ia, w_iend;
    logic [8:0]  w_yy, w_sum;
    logic [12:0] w_isum;
    logic [14:0] w_tprod;
    logic [63:0] w_mask, w_row;
    logic        w_acc, w_vy_ok;

    assign w_hi  = r_op[15:12];
    assign w_x   = r_op[11:8];
    assign w_y   = r_op[7:4];
    assign w_n   = r_op[3:0];
    assign w_nn  = r_op[7:0];
    assign w_nnn = r_op[11:0];
    assign w_pc2 = r_pc + 12'd2;
    assign w_ia  = r_i + {8'd0, r_cnt};
    assign w_iend = r_i + {8'd0, w_x} + 12'd1;
    assign w_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // second register read: V0 for the offset jump, else VY
    assign w_vy_ok = r_rv[w_rra];
    assign w_vy  = w_vy_ok ? w_rrd : 8'd0;
    assign w_rv  = w_vy;
    assign w_sum = {1'b0, r_vx} + {1'b0, w_vy};
    assign w_isum = {1'b0, r_i} + {5'd0, r_vx};

    // BCD: hundreds by compare, tens by reciprocal multiply (valid below 100)
    assign w_hund = (r_vx >= 8'd200) ? 8'd2 : (r_vx >= 8'd100) ? 8'd1 : 8'd0;
    assign w_rem  = r_vx - ((r_vx >= 8'd200) ? 8'd200 : (r_vx >= 8'd100) ? 8'd100 : 8'd0);
    assign w_tprod = 15'(w_rem) * 15'd205;
    assign w_ten  = {4'd0, w_tprod[14:11]};
    assign w_one  = w_rem - 8'(w_ten * 8'd10);

    // sprite row placement, clipped at the right edge
    assign w_yy   = {1'b0, r_vy} + {5'd0, r_cnt};
    assign w_mask = (r_vx < 8'd64) ? ({r_bits, 56'd0} >> r_vx[5:0]) : 64'd0;
    assign w_row  = r_fv[w_yy[4:0]] ? w_frd : 64'd0;

    always_comb begin
        w_key_hi = 8'd0;
        for (int k = 0; k < 16; k++) begin
            if (r_keys[k]) begin
                w_key_hi = 8'(k);
            end
        end
    end

    // read address selection
    always_comb begin
        case (r_state)
            S_F1:          w_mra = MAW'(r_pc + 12'd1);
            S_DM, S_LDR:   w_mra = MAW'(w_ia);
            default:       w_mra = MAW'(r_pc);
        endcase
        case (r_state)
            S_RY:    w_rra = (w_hi == OP_JPV0) ? 4'd0 : w_y;
            S_EXEC:  w_rra = (w_hi == OP_JPV0) ? 4'd0 : w_y;
            S_SVR:   w_rra = r_cnt;
            S_SVW:   w_rra = r_cnt;
            default: w_rra = w_x;
        endcase
        w_fra = (r_state == S_DF || r_state == S_DW) ? w_yy[4:0] : i_in.row;
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr; n_pc = r_pc; n_i = r_i; n_op = r_op;
        n_keys = r_keys; n_vx = r_vx; n_vy = r_vy; n_dt = r_dt; n_st = r_st;
        n_bits = r_bits; n_rnd = r_rnd; n_sp = r_sp; n_cnt = r_cnt;
        n_draw = r_draw; n_beep = r_beep; n_wait = r_wait; n_hit = r_hit;
        n_flag = r_flag; n_row = r_row; n_pix = r_pix;
        n_fv = r_fv; n_rv = r_rv; n_sv = r_sv; n_out = r_out;
        n_ov = r_ov && i_out_stall;
        w_mwe = 1'b0; w_mwa = MAW'(w_ia); w_mwd = 8'd0;
        w_rwe = 1'b0; w_rwa = w_x; w_rwd = 8'd0;
        w_fwe = 1'b0; w_fwa = w_yy[4:0]; w_fwd = w_row ^ w_mask;
        w_swe = 1'b0;

        case (r_state)
            S_CLR: begin
                w_mwe = 1'b1;
                w_mwa = r_clr[MAW-1:0];
                w_mwd = (r_clr < (MAW+1)'(FONT_BYTES)) ? FONT[r_clr[6:0]] : 8'd0;
                n_clr = r_clr + (MAW+1)'(1);
                if (r_clr == (MAW+1)'(MEMORY_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_acc) begin
                    n_op = 16'd0; n_beep = 1'b0; n_wait = 1'b0; n_pix = 64'd0;
                    n_rnd = i_in.random_byte; n_row = i_in.row;
                    case (i_in.command)
                        CMD_STEP: begin
                            n_state = S_F0;
                        end
                        CMD_LOAD: begin
                            w_mwe = 1'b1;
                            w_mwa = MAW'(i_in.address);
                            w_mwd = i_in.data;
                            n_state = S_DONE;
                        end
                        CMD_KEY: begin
                            n_keys[PAD_MAP[i_in.key_code]] = i_in.key_down;
                            n_state = S_DONE;
                        end
                        default: n_state = S_RDROW;
                    endcase
                end
            end
            S_RDROW: begin
                n_pix = r_fv[r_row] ? w_frd : 64'd0;
                n_draw = 1'b0;
                n_state = S_DONE;
            end
            S_F0: n_state = S_F1;
            S_F1: begin
                n_op[15:8] = w_mrd;
                n_state = S_F2;
            end
            S_F2: begin
                n_op[7:0] = w_mrd;
                n_state = S_RX;
            end
            S_RX: n_state = S_RY;
            S_RY: begin
                n_vx = r_rv[w_x] ? w_rrd : 8'd0;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_vy = w_vy;
                n_pc = w_pc2;
                n_state = S_TICK;
                case (w_hi)
                    OP_SYS: begin
                        if (r_op == OP_CLS) begin
                            n_fv = '0;
                            n_draw = 1'b1;
                        end else if (r_op == OP_RET) begin
                            n_state = S_RET;
                        end
                    end
                    OP_JP: n_pc = w_nnn;
                    OP_CALL: begin
                        w_swe = 1'b1;
                        n_sv[r_sp] = 1'b1;
                        n_sp = sp_inc(r_sp);
                        n_pc = w_nnn;
                    end
                    OP_SEI:  if (r_vx == w_nn) n_pc = r_pc + 12'd4;
                    OP_SNEI: if (r_vx != w_nn) n_pc = r_pc + 12'd4;
                    OP_SER:  if (r_vx == w_vy) n_pc = r_pc + 12'd4;
                    OP_SNER: if (r_vx != w_vy) n_pc = r_pc + 12'd4;
                    OP_LDI: begin
                        w_rwe = 1'b1; w_rwd = w_nn;
                    end
                    OP_ADDI: begin
                        w_rwe = 1'b1; w_rwd = r_vx + w_nn;
                    end
                    OP_ALU: begin
                        w_rwe = 1'b1;
                        n_state = S_WF;
                        case (w_n)
                            ALU_MOV: begin w_rwd = w_vy; n_state = S_TICK; end
                            ALU_OR:  begin w_rwd = r_vx | w_vy; n_state = S_TICK; end
                            ALU_AND: begin w_rwd = r_vx & w_vy; n_state = S_TICK; end
                            ALU_XOR: begin w_rwd = r_vx ^ w_vy; n_state = S_TICK; end
                            ALU_ADD: begin w_rwd = w_sum[7:0]; n_flag = w_sum[8]; end
                            ALU_SUB: begin w_rwd = r_vx - w_vy; n_flag = r_vx >= w_vy; end
                            ALU_SHR: begin w_rwd = r_vx >> 1; n_flag = r_vx[0]; end
                            ALU_SBN: begin w_rwd = w_vy - r_vx; n_flag = w_vy >= r_vx; end
                            ALU_SHL: begin w_rwd = r_vx << 1; n_flag = r_vx[7]; end
                            default: begin w_rwe = 1'b0; n_state = S_TICK; end
                        endcase
                    end
                    OP_LDIX: n_i = w_nnn;
                    OP_JPV0: n_pc = w_nnn + {4'd0, w_rv};
                    OP_RND: begin
                        w_rwe = 1'b1; w_rwd = r_rnd & w_nn;
                    end
                    OP_DRW: begin
                        n_cnt = 4'd0;
                        n_hit = 1'b0;
                        if (w_n == 4'd0) begin
                            n_flag = 1'b0;
                            n_draw = 1'b1;
                            n_state = S_WF;
                        end else begin
                            n_state = S_DM;
                        end
                    end
                    OP_KEY: begin
                        if (w_nn == KEY_DOWN_SKIP && r_keys[r_vx[3:0]]) begin
                            n_pc = r_pc + 12'd4;
                        end else if (w_nn == KEY_UP_SKIP && !r_keys[r_vx[3:0]]) begin
                            n_pc = r_pc + 12'd4;
                        end
                    end
                    default: begin
                        n_cnt = 4'd0;
                        case (w_nn)
                            F_GETDT: begin w_rwe = 1'b1; w_rwd = r_dt; end
                            F_WAIT: begin
                                if (r_keys == 16'd0) begin
                                    n_wait = 1'b1;
                                    n_pc = r_pc;
                                end else begin
                                    w_rwe = 1'b1; w_rwd = w_key_hi;
                                end
                            end
                            F_SETDT: n_dt = r_vx;
                            F_SETST: n_st = r_vx;
                            F_ADDI: begin
                                n_i = w_isum[11:0];
                                n_flag = w_isum[12];
                                n_state = S_WF;
                            end
                            F_FONT: n_i = 12'(({2'd0, r_vx, 2'd0}) + {4'd0, r_vx});
                            F_BCD:  n_state = S_BCD;
                            F_SAVE: n_state = S_SVR;
                            F_LOAD: n_state = S_LDR;
                            default: ;
                        endcase
                    end
                endcase
                if (w_rwe) begin
                    n_rv[w_x] = 1'b1;
                end
            end
            S_RET: begin
                n_pc = (r_sv[sp_dec(r_sp)] ? w_srd : 12'd0) + 12'd2;
                n_sp = sp_dec(r_sp);
                n_state = S_TICK;
            end
            S_WF: begin
                w_rwe = 1'b1; w_rwa = 4'hF; w_rwd = {7'd0, r_flag};
                n_rv[15] = 1'b1;
                n_state = S_TICK;
            end
            S_DM: n_state = S_DF;
            S_DF: begin
                n_bits = w_mrd;
                n_state = S_DW;
            end
            S_DW: begin
                if (w_yy < 9'd32) begin
                    w_fwe = 1'b1;
                    n_fv[w_yy[4:0]] = 1'b1;
                    if ((w_row & w_mask) != 64'd0) begin
                        n_hit = 1'b1;
                    end
                end
                n_cnt = r_cnt + 4'd1;
                n_state = S_DM;
                if (r_cnt == w_n - 4'd1) begin
                    n_flag = n_hit;
                    n_draw = 1'b1;
                    n_state = S_WF;
                end
            end
            S_BCD: begin
                w_mwe = 1'b1;
                w_mwd = (r_cnt == 4'd0) ? w_hund : (r_cnt == 4'd1) ? w_ten : w_one;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd2) begin
                    n_state = S_TICK;
                end
            end
            S_SVR: n_state = S_SVW;
            S_SVW: begin
                w_mwe = 1'b1;
                w_mwd = w_vy;
                n_cnt = r_cnt + 4'd1;
                n_state = S_SVR;
                if (r_cnt == w_x) begin
                    n_i = w_iend;
                    n_state = S_TICK;
                end
            end
            S_LDR: n_state = S_LDW;
            S_LDW: begin
                w_rwe = 1'b1; w_rwa = r_cnt; w_rwd = w_mrd;
                n_rv[r_cnt] = 1'b1;
                n_cnt = r_cnt + 4'd1;
                n_state = S_LDR;
                if (r_cnt == w_x) begin
                    n_i = w_iend;
                    n_state = S_TICK;
                end
            end
            S_TICK: begin
                if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
                if (r_st != 8'd0) n_st = r_st - 8'd1;
                n_beep = (r_st == 8'd1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_out.pc_now       = r_pc;
                    n_out.opcode_done  = r_op;
                    n_out.draw_pending = r_draw;
                    n_out.beep         = r_beep;
                    n_out.waiting_key  = r_wait;
                    n_out.row_pixels   = r_pix;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_clr <= '0; r_pc <= PC_RESET; r_i <= '0;
            r_keys <= '0; r_dt <= '0; r_st <= '0; r_sp <= '0; r_draw <= 1'b0;
            r_fv <= '0; r_rv <= '0; r_sv <= '0; r_ov <= 1'b0; r_cnt <= '0;
        end else begin
            r_state <= n_state; r_clr <= n_clr; r_pc <= n_pc; r_i <= n_i;
            r_keys <= n_keys; r_dt <= n_dt; r_st <= n_st; r_sp <= n_sp;
            r_draw <= n_draw; r_fv <= n_fv; r_rv <= n_rv; r_sv <= n_sv;
            r_ov <= n_ov; r_cnt <= n_cnt;
        end
        r_op <= n_op; r_vx <= n_vx; r_vy <= n_vy; r_bits <= n_bits;
        r_rnd <= n_rnd; r_beep <= n_beep; r_wait <= n_wait; r_hit <= n_hit;
        r_flag <= n_flag; r_row <= n_row; r_pix <= n_pix; r_out <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out = r_out;
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for the CHIP-8 style CPU with sprite display.
// Depends on c8cpu_pkg and bytecode_vm_cpu_with_sprite_display; a scoreboard
// class predicts each result word from a shadow copy of the CPU state.
module tb_top;
    import c8cpu_pkg::*;

    // ------------------------------------------------------------------
    // Scoreboard: shadow CPU state plus a queue of predicted result words.
    // ------------------------------------------------------------------
    class chip8_scoreboard;
        logic [7:0]  mem [4096];
        logic [63:0] frame [32];
        logic [7:0]  vreg [16];
        logic [11:0] stk [16];
        int unsigned sp;
        logic [11:0] pc;
        logic [11:0] ireg;
        logic [15:0] keys;
        logic [7:0]  dt;
        logic [7:0]  st;
        logic        drawn;
        t_out        pending [$];
        int          errors;

        function void clear_state();
            foreach (mem[a]) mem[a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
            foreach (frame[r]) frame[r] = '0;
            foreach (vreg[r]) vreg[r] = '0;
            foreach (stk[r]) stk[r] = '0;
            sp = 0; pc = PC_RESET; ireg = '0; keys = '0;
            dt = '0; st = '0; drawn = 1'b0; errors = 0;
        endfunction

        function void blit(logic [7:0] x0, logic [7:0] y0, logic [3:0] n);
            logic hit;
            logic [7:0] bits;
            int yy, xx;
            hit = 1'b0;
            for (int r = 0; r < n; r++) begin
                bits = mem[(ireg + r) & 12'hFFF];
                yy = y0 + r;
                if (yy >= ROWS) continue;
                for (int c = 0; c < 8; c++) begin
                    xx = x0 + c;
                    if (xx >= COLS || !bits[7-c]) continue;
                    if (frame[yy][63-xx]) hit = 1'b1;
                    frame[yy][63-xx] ^= 1'b1;
                end
            end
            vreg[15] = {7'd0, hit};
            drawn = 1'b1;
        endfunction

        // Executes one opcode; returns 1 when FX0A sees no key held.
        function logic run_op(logic [15:0] op, logic [7:0] rnd);
            logic [3:0] x, y;
            logic [7:0] nn, vx, vy;
            logic [11:0] nnn, nxt;
            logic [12:0] sum13;
            logic [8:0] sum9;
            logic hold;
            x = op[11:8]; y = op[7:4]; nn = op[7:0]; nnn = op[11:0];
            vx = vreg[x]; vy = vreg[y];
            nxt = pc + 12'd2;
            hold = 1'b0;
            case (op[15:12])
                OP_SYS: begin
                    if (op == OP_CLS) begin
                        foreach (frame[r]) frame[r] = '0;
                        drawn = 1'b1;
                    end else if (op == OP_RET) begin
                        sp = (sp + 15) % 16;
                        nxt = stk[sp] + 12'd2;
                    end
                end
                OP_JP:   nxt = nnn;
                OP_CALL: begin
                    stk[sp] = pc;
                    sp = (sp + 1) % 16;
                    nxt = nnn;
                end
                OP_SEI:  if (vx == nn) nxt += 12'd2;
                OP_SNEI: if (vx != nn) nxt += 12'd2;
                OP_SER:  if (vx == vy) nxt += 12'd2;
                OP_LDI:  vreg[x] = nn;
                OP_ADDI: vreg[x] = vx + nn;
                OP_ALU: begin
                    case (op[3:0])
                        ALU_MOV: vreg[x] = vy;
                        ALU_OR:  vreg[x] = vx | vy;
                        ALU_AND: vreg[x] = vx & vy;
                        ALU_XOR: vreg[x] = vx ^ vy;
                        ALU_ADD: begin
                            sum9 = vx + vy;
                            vreg[x] = sum9[7:0];
                            vreg[15] = {7'd0, sum9[8]};
                        end
                        ALU_SUB: begin
                            vreg[x] = vx - vy;
                            vreg[15] = {7'd0, vx >= vy};
                        end
                        ALU_SHR: begin
                            vreg[x] = vx >> 1;
                            vreg[15] = {7'd0, vx[0]};
                        end
                        ALU_SBN: begin
                            vreg[x] = vy - vx;
                            vreg[15] = {7'd0, vy >= vx};
                        end
                        ALU_SHL: begin
                            vreg[x] = vx << 1;
                            vreg[15] = {7'd0, vx[7]};
                        end
                        default: ;
                    endcase
                end
                OP_SNER: if (vx != vy) nxt += 12'd2;
                OP_LDIX: ireg = nnn;
                OP_JPV0: nxt = nnn + vreg[0];
                OP_RND:  vreg[x] = rnd & nn;
                OP_DRW:  blit(vx, vy, op[3:0]);
                OP_KEY: begin
                    if (nn == KEY_DOWN_SKIP && keys[vx[3:0]]) nxt += 12'd2;
                    else if (nn == KEY_UP_SKIP && !keys[vx[3:0]]) nxt += 12'd2;
                end
                default: begin
                    case (nn)
                        F_GETDT: vreg[x] = dt;
                        F_WAIT: begin
                            if (keys == '0) begin
                                hold = 1'b1;
                                nxt = pc;
                            end else begin
                                for (int k = 0; k < 16; k++)
                                    if (keys[k]) vreg[x] = k[7:0];
                            end
                        end
                        F_SETDT: dt = vx;
                        F_SETST: st = vx;
                        F_ADDI: begin
                            sum13 = ireg + vx;
                            ireg = sum13[11:0];
                            vreg[15] = {7'd0, sum13[12]};
                        end
                        F_FONT: ireg = 12'(5 * vx);
                        F_BCD: begin
                            mem[ireg] = vx / 100;
                            mem[ireg + 12'd1] = (vx / 10) % 10;
                            mem[ireg + 12'd2] = vx % 10;
                        end
                        F_SAVE: begin
                            for (int k = 0; k <= x; k++) mem[ireg + 12'(k)] = vreg[k];
                            ireg = ireg + x + 12'd1;
                        end
                        F_LOAD: begin
                            for (int k = 0; k <= x; k++) vreg[k] = mem[ireg + 12'(k)];
                            ireg = ireg + x + 12'd1;
                        end
                        default: ;
                    endcase
                end
            endcase
            pc = nxt;
            return hold;
        endfunction

        // Accepted input word: advance the shadow and queue its result.
        function void note_input(t_in w);
            t_out r;
            r = '0;
            case (w.command)
                CMD_STEP: begin
                    r.opcode_done = {mem[pc], mem[pc + 12'd1]};
                    r.waiting_key = run_op(r.opcode_done, w.random_byte);
                    if (dt != 0) dt--;
                    if (st != 0) begin
                        r.beep = (st == 8'd1);
                        st--;
                    end
                end
                CMD_LOAD: mem[w.address] = w.data;
                CMD_KEY:  keys[PAD_MAP[w.key_code]] = w.key_down;
                default: begin
                    r.row_pixels = frame[w.row];
                    drawn = 1'b0;
                end
            endcase
            r.pc_now = pc;
            r.draw_pending = drawn;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report("unexpected word", 64'(got), 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.pc_now != want.pc_now) report("pc_now", got.pc_now, want.pc_now);
            if (got.opcode_done != want.opcode_done)
                report("opcode_done", got.opcode_done, want.opcode_done);
            if (got.draw_pending != want.draw_pending)
                report("draw_pending", got.draw_pending, want.draw_pending);
            if (got.beep != want.beep) report("beep", got.beep, want.beep);
            if (got.waiting_key != want.waiting_key)
                report("waiting_key", got.waiting_key, want.waiting_key);
            if (got.row_pixels != want.row_pixels)
                report("row_pixels", got.row_pixels, want.row_pixels);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    bytecode_vm_cpu_with_sprite_display dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    chip8_scoreboard sb;
    bit      stim_done;
    bit      hold_off;      // long receiver stall requested by the sender side
    int      idle_cycles;
    int      cmd_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Random gap length in cycles; the upper range is picked in 8 of 100 draws.
    function automatic int pick_gap();
        if ($urandom_range(99) < 8) return $urandom_range(60, 10);
        return $urandom_range(2);
    endfunction

    // Offer one word and hold it until the CPU takes it; with no gap the next
    // word is driven on the same edge the previous one is accepted, else valid
    // is dropped for a random gap before the next word is raised.
    task automatic send_word(t_in w);
        int gap;
        gap = ($urandom_range(3) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
        cmd_count++;
    endtask

    function automatic t_in noise_word(logic [1:0] cmd);
        t_in w;
        w.command = cmd;
        w.address = 12'($urandom);
        w.data = 8'($urandom);
        w.key_code = 4'($urandom);
        w.key_down = 1'($urandom);
        w.random_byte = 8'($urandom);
        w.row = 5'($urandom);
        return w;
    endfunction

    task automatic load_byte(logic [11:0] a, logic [7:0] d);
        t_in w;
        w = noise_word(CMD_LOAD);
        w.address = a;
        w.data = d;
        send_word(w);
    endtask

    // Places an opcode at the current pc of the shadow and steps it.
    task automatic exec_op(logic [15:0] op);
        t_in w;
        load_byte(sb.pc, op[15:8]);
        load_byte(sb.pc + 12'd1, op[7:0]);
        w = noise_word(CMD_STEP);
        send_word(w);
    endtask

    task automatic key_event(logic [3:0] code, logic down);
        t_in w;
        w = noise_word(CMD_KEY);
        w.key_code = code;
        w.key_down = down;
        send_word(w);
    endtask

    task automatic read_row(logic [4:0] r);
        t_in w;
        w = noise_word(CMD_ROW);
        w.row = r;
        send_word(w);
    endtask

    // Random opcode biased toward meaningful encodings; register save/load
    // and sprites use the full register and height range.
    function automatic logic [15:0] rand_op();
        logic [15:0] op;
        logic [7:0] fsel [11];
        fsel = '{F_GETDT, F_WAIT, F_SETDT, F_SETST, F_ADDI, F_FONT, F_BCD,
                 F_SAVE, F_LOAD, 8'h00, 8'hFF};
        op = 16'($urandom);
        case ($urandom_range(9))
            0: op[15:12] = OP_LDI;
            1: op[15:12] = OP_ADDI;
            2: op[15:12] = OP_ALU;
            3: begin
                op[15:12] = 4'hF;
                op[7:0] = fsel[$urandom_range(10)];
            end
            4: begin
                op[15:12] = OP_KEY;
                op[7:0] = $urandom_range(1) ? KEY_DOWN_SKIP : KEY_UP_SKIP;
            end
            5: begin
                op[15:12] = OP_DRW;
                op[3:0] = 4'($urandom_range(15));
            end
            6: op = ($urandom_range(1)) ? OP_CLS : OP_RET;
            default: ;
        endcase
        return op;
    endfunction

    // Sender
    initial begin
        t_in w;
        sb = new();
        sb.clear_state();
        stim_done = 1'b0;
        hold_off = 1'b0;
        cmd_count = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ALU flags, shifts, font, BCD, save/load, sprites
        exec_op(16'h60FF);              // V0 = FF
        exec_op(16'h6101);              // V1 = 01
        exec_op(16'h8014);              // add with carry
        exec_op(16'h8015);              // sub with borrow
        exec_op(16'h8017);
        exec_op(16'h800E);
        exec_op(16'h8006);
        exec_op(16'h0123);              // system call
        exec_op(16'h5011);              // low nibble ignored
        exec_op(16'hF029);              // font address from all of VX
        exec_op(16'hF033);
        exec_op(16'hFF55);
        exec_op(16'hFF65);
        exec_op(16'h6A3E);
        exec_op(16'h6B1E);
        exec_op(16'hDAB5);              // clipped at both edges
        exec_op(16'hDAB0);              // zero-height sprite
        read_row(5'd31);
        exec_op(16'hF10A);              // waits, no key held
        key_event(4'hF, 1'b1);
        exec_op(16'hF10A);
        exec_op(16'h60FF);
        exec_op(16'hF018);
        exec_op(16'hFFFF);              // undefined
        exec_op(16'h2FFE);              // call at top of memory

        // Long receiver hold-off while commands keep coming; the receiver
        // clears the request once its stretch is over.
        hold_off = 1'b1;
        for (int k = 0; k < 570; k++) begin
            case ($urandom_range(19))
                0, 1: send_word(noise_word(CMD_LOAD));
                2: send_word(noise_word(CMD_KEY));
                3: send_word(noise_word(CMD_ROW));
                4: send_word(noise_word(CMD_STEP));
                default: exec_op(rand_op());
            endcase
        end
        i_in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus a long stretch while hold_off is set.
    initial begin
        int gap;
        i_out_stall <= 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(3) == 0) ? pick_gap() : 0;
            i_out_stall <= (gap != 0);
            repeat (gap) @(posedge i_clk);
            i_out_stall <= 1'b0;
            repeat ($urandom_range(20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
    end

    // Watchdog on cycles without any handshake; covers the reset sweep.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        idle_cycles = 0;
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
